// ===== rtl/tile_blit_span_generator_defines.svh =====
// Assertion macros used by the span generator checker
`ifndef TILE_BLIT_SPAN_GENERATOR_DEFINES_SVH
`define TILE_BLIT_SPAN_GENERATOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define TBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define TBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tbs_pkg.sv =====
// Shared types, widths and register codes of the tile blit span generator
package tbs_pkg;

    localparam int IDX_W     = 12;
    localparam int SIDE_W    = 7;
    localparam int COLS_W    = 9;
    localparam int PITCH_W   = 13;
    localparam int TGT_W     = 12;
    localparam int SRC_W     = 32;
    localparam int DST_W     = 22;
    localparam int PART_W    = IDX_W + SIDE_W;
    localparam int DY_W      = 2 * TGT_W;
    localparam int SPAN_CAP  = 64;

    localparam int DEF_MAX_TILE_SIDE = 64;
    localparam int DEF_COORD_BITS    = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILESET_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PITCH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT   = 3'd5;

    // Register reset values
    localparam logic [SIDE_W-1:0]  RST_TILE_WIDTH      = 7'd16;
    localparam logic [SIDE_W-1:0]  RST_TILE_HEIGHT     = 7'd16;
    localparam logic [COLS_W-1:0]  RST_TILESET_COLUMNS = 9'd16;
    localparam logic [PITCH_W-1:0] RST_SOURCE_PITCH    = 13'd256;
    localparam logic [TGT_W-1:0]   RST_TARGET_WIDTH    = 12'd320;
    localparam logic [TGT_W-1:0]   RST_TARGET_HEIGHT   = 12'd240;

    typedef struct packed {
        logic [SIDE_W-1:0]  tile_width;
        logic [SIDE_W-1:0]  tile_height;
        logic [COLS_W-1:0]  tileset_columns;
        logic [PITCH_W-1:0] source_pitch;
        logic [TGT_W-1:0]   target_width;
        logic [TGT_W-1:0]   target_height;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic check;
        logic div_step;
        logic mul1;
        logic mul2;
        logic load_span;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic last_row;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/tbs_ifs.sv =====
// Channel interfaces: tile requests, span results and register writes
interface tbs_tile_if #(
    parameter int COORD_BITS = tbs_pkg::DEF_COORD_BITS
);
    logic                          valid;
    logic                          ready;
    logic [tbs_pkg::IDX_W-1:0]     tile_index;
    logic signed [COORD_BITS-1:0]  x_pos;
    logic signed [COORD_BITS-1:0]  y_pos;

    modport source (output valid, tile_index, x_pos, y_pos, input ready);
    modport sink (input valid, tile_index, x_pos, y_pos, output ready);
endinterface

interface tbs_span_if;
    logic                        valid;
    logic                        ready;
    logic [tbs_pkg::SRC_W-1:0]   src_addr;
    logic [tbs_pkg::DST_W-1:0]   dest_addr;
    logic [tbs_pkg::SIDE_W-1:0]  span_width;
    logic                        last_span;

    modport source (output valid, src_addr, dest_addr, span_width, last_span, input ready);
    modport sink (input valid, src_addr, dest_addr, span_width, last_span, output ready);
endinterface

interface tbs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbs_pkg::CFG_IDX_W-1:0]   index;
    logic [tbs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tbs_cfg_regs.sv =====
// Configuration register file of the tile blit span generator
module tbs_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]  wr_data,
    output tbs_pkg::cfg_t                   cfg
);

    tbs_pkg::cfg_t cfg_reg;
    tbs_pkg::cfg_t cfg_next;

    // Update the addressed register, ignore unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                tbs_pkg::REG_TILE_WIDTH:
                    cfg_next.tile_width = wr_data[tbs_pkg::SIDE_W-1:0];
                tbs_pkg::REG_TILE_HEIGHT:
                    cfg_next.tile_height = wr_data[tbs_pkg::SIDE_W-1:0];
                tbs_pkg::REG_TILESET_COLUMNS:
                    cfg_next.tileset_columns = wr_data[tbs_pkg::COLS_W-1:0];
                tbs_pkg::REG_SOURCE_PITCH:
                    cfg_next.source_pitch = wr_data[tbs_pkg::PITCH_W-1:0];
                tbs_pkg::REG_TARGET_WIDTH:
                    cfg_next.target_width = wr_data[tbs_pkg::TGT_W-1:0];
                tbs_pkg::REG_TARGET_HEIGHT:
                    cfg_next.target_height = wr_data[tbs_pkg::TGT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width      <= tbs_pkg::RST_TILE_WIDTH;
            cfg_reg.tile_height     <= tbs_pkg::RST_TILE_HEIGHT;
            cfg_reg.tileset_columns <= tbs_pkg::RST_TILESET_COLUMNS;
            cfg_reg.source_pitch    <= tbs_pkg::RST_SOURCE_PITCH;
            cfg_reg.target_width    <= tbs_pkg::RST_TARGET_WIDTH;
            cfg_reg.target_height   <= tbs_pkg::RST_TARGET_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tbs_ctrl.sv =====
// Sequencer of the span generator: check, divide, multiply, emit
module tbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tbs_pkg::dp_status_t  status,
    output tbs_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam int CNT_W = $clog2(tbs_pkg::IDX_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tbs_pkg::IDX_W - 1);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0] div_cnt_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check    = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                // Drop rejected or fully clipped tiles
                if (status.skip)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (div_cnt_reg == CNT_LAST)
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        div_cnt_next = div_cnt_reg + 1'b1;
                    end
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Advance one row whenever the result register frees up
                if (status.out_free)
                begin
                    cmd.load_span = 1'b1;
                    if (status.last_row)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// ===== rtl/tbs_dpath.sv =====
// Datapath: clip check, serial divider, address multipliers, row stepping
module tbs_dpath #(
    parameter int MAX_TILE_SIDE = tbs_pkg::DEF_MAX_TILE_SIDE,
    parameter int COORD_BITS    = tbs_pkg::DEF_COORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tbs_pkg::cfg_t                  cfg,
    input  logic [tbs_pkg::IDX_W-1:0]      tile_index,
    input  logic signed [COORD_BITS-1:0]   x_pos,
    input  logic signed [COORD_BITS-1:0]   y_pos,
    input  tbs_pkg::dp_cmd_t               cmd,
    output tbs_pkg::dp_status_t            status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [tbs_pkg::SRC_W-1:0]      src_addr,
    output logic [tbs_pkg::DST_W-1:0]      dest_addr,
    output logic [tbs_pkg::SIDE_W-1:0]     span_width,
    output logic                           last_span
);

    localparam int SIDE_W  = tbs_pkg::SIDE_W;
    localparam int IDX_W   = tbs_pkg::IDX_W;
    localparam int TGT_W   = tbs_pkg::TGT_W;
    localparam int PART_W  = tbs_pkg::PART_W;
    localparam int DY_W    = tbs_pkg::DY_W;
    localparam int SRC_W   = tbs_pkg::SRC_W;
    localparam int DST_W   = tbs_pkg::DST_W;
    localparam int SIDE_LIM = (MAX_TILE_SIDE < tbs_pkg::SPAN_CAP) ? MAX_TILE_SIDE
                                                                  : tbs_pkg::SPAN_CAP;
    // Working width for signed coordinate compares
    localparam int WB = ((COORD_BITS > TGT_W + 1) ? COORD_BITS : TGT_W + 1) + 2;

    // Saturated tile sides
    logic [SIDE_W-1:0] tw_eff;
    logic [SIDE_W-1:0] th_eff;

    assign tw_eff = (cfg.tile_width > SIDE_W'(SIDE_LIM)) ? SIDE_W'(SIDE_LIM) : cfg.tile_width;
    assign th_eff = (cfg.tile_height > SIDE_W'(SIDE_LIM)) ? SIDE_W'(SIDE_LIM)
                                                          : cfg.tile_height;

    // Captured request
    logic [IDX_W-1:0]             idx_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            idx_reg <= tile_index;
            x_reg   <= x_pos;
            y_reg   <= y_pos;
        end
    end

    // Clip check on both axes
    logic signed [WB-1:0] xs, ys, twv, thv, gwv, ghv;
    logic signed [WB-1:0] x_end, x_hi, x_lo, x_span, x_neg;
    logic signed [WB-1:0] y_end, y_hi, y_lo, y_span, y_neg;
    logic                 reject, empty;

    always_comb
    begin
        xs  = $signed({{(WB-COORD_BITS){x_reg[COORD_BITS-1]}}, x_reg});
        ys  = $signed({{(WB-COORD_BITS){y_reg[COORD_BITS-1]}}, y_reg});
        twv = $signed({{(WB-SIDE_W){1'b0}}, tw_eff});
        thv = $signed({{(WB-SIDE_W){1'b0}}, th_eff});
        gwv = $signed({{(WB-TGT_W){1'b0}}, cfg.target_width});
        ghv = $signed({{(WB-TGT_W){1'b0}}, cfg.target_height});

        reject = (xs < -twv) || (xs > gwv + twv) || (ys < -thv) || (ys > ghv + thv);

        x_end  = xs + twv;
        x_hi   = (x_end > gwv) ? gwv : x_end;
        x_lo   = xs[WB-1] ? '0 : xs;
        x_span = x_hi - x_lo;
        x_neg  = -xs;

        y_end  = ys + thv;
        y_hi   = (y_end > ghv) ? ghv : y_end;
        y_lo   = ys[WB-1] ? '0 : ys;
        y_span = y_hi - y_lo;
        y_neg  = -ys;

        empty = x_span[WB-1] || (x_span == '0) || y_span[WB-1] || (y_span == '0);
    end

    logic              skip_reg;
    logic [TGT_W-1:0]  x_lo_reg;
    logic [TGT_W-1:0]  y_lo_reg;
    logic [SIDE_W-1:0] clip_left_reg;
    logic [SIDE_W-1:0] clip_top_reg;
    logic [SIDE_W-1:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
        end
        else if (cmd.check)
        begin
            skip_reg <= reject || empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            x_lo_reg      <= x_lo[TGT_W-1:0];
            y_lo_reg      <= y_lo[TGT_W-1:0];
            clip_left_reg <= xs[WB-1] ? x_neg[SIDE_W-1:0] : '0;
            clip_top_reg  <= ys[WB-1] ? y_neg[SIDE_W-1:0] : '0;
            width_reg     <= x_span[SIDE_W-1:0];
        end
    end

    // Restoring divider, one quotient bit per step
    logic [IDX_W-1:0] rem_reg;
    logic [IDX_W-1:0] quo_reg;
    logic [IDX_W:0]   trial;
    logic [IDX_W:0]   divisor;
    logic             fits;
    logic [IDX_W:0]   trial_diff;

    assign trial      = {rem_reg, quo_reg[IDX_W-1]};
    assign divisor    = {{(IDX_W+1-tbs_pkg::COLS_W){1'b0}}, cfg.tileset_columns};
    assign fits       = (trial >= divisor);
    assign trial_diff = trial - divisor;

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            rem_reg <= '0;
            quo_reg <= idx_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? trial_diff[IDX_W-1:0] : trial[IDX_W-1:0];
            quo_reg <= {quo_reg[IDX_W-2:0], fits};
        end
    end

    // First multiply stage: tile row, tile column, destination row
    logic [PART_W-1:0] row_prod;
    logic [PART_W-1:0] col_prod;
    logic [DY_W-1:0]   dy_prod;
    logic [PART_W-1:0] row_part_reg;
    logic [PART_W-1:0] col_part_reg;
    logic [DY_W-1:0]   dy_reg;

    assign row_prod = PART_W'(quo_reg) * PART_W'(th_eff);
    assign col_prod = PART_W'(rem_reg) * PART_W'(tw_eff);
    assign dy_prod  = DY_W'(y_lo_reg) * DY_W'(cfg.target_width);

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            row_part_reg <= row_prod + PART_W'(clip_top_reg);
            col_part_reg <= col_prod + PART_W'(clip_left_reg);
            dy_reg       <= dy_prod;
        end
    end

    // Second multiply stage and row stepping
    logic [SRC_W-1:0]  src_prod;
    logic [DY_W-1:0]   dst_sum;
    logic [SRC_W-1:0]  src_row_reg;
    logic [DST_W-1:0]  dest_row_reg;
    logic [SIDE_W-1:0] rows_left_reg;

    assign src_prod = SRC_W'(row_part_reg) * SRC_W'(cfg.source_pitch);
    assign dst_sum  = dy_reg + DY_W'(x_lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_left_reg <= '0;
        end
        else if (cmd.check)
        begin
            rows_left_reg <= y_span[SIDE_W-1:0];
        end
        else if (cmd.load_span)
        begin
            rows_left_reg <= rows_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul2)
        begin
            src_row_reg  <= src_prod + SRC_W'(col_part_reg);
            dest_row_reg <= dst_sum[DST_W-1:0];
        end
        else if (cmd.load_span)
        begin
            src_row_reg  <= src_row_reg + SRC_W'(cfg.source_pitch);
            dest_row_reg <= dest_row_reg + DST_W'(cfg.target_width);
        end
    end

    // Result register: hold while stalled, reload when taken
    logic              out_valid_reg;
    logic [SRC_W-1:0]  out_src_reg;
    logic [DST_W-1:0]  out_dest_reg;
    logic [SIDE_W-1:0] out_width_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_span)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_span)
        begin
            out_src_reg   <= src_row_reg;
            out_dest_reg  <= dest_row_reg;
            out_width_reg <= width_reg;
            out_last_reg  <= (rows_left_reg == SIDE_W'(1));
        end
    end

    assign status.skip     = skip_reg;
    assign status.last_row = (rows_left_reg == SIDE_W'(1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign src_addr   = out_src_reg;
    assign dest_addr  = out_dest_reg;
    assign span_width = out_width_reg;
    assign last_span  = out_last_reg;

endmodule

// ===== rtl/tile_blit_span_generator.sv =====
// Top level of the clipped tile blit span generator
//
// Channels: tile_in takes one tile draw request (tile index, signed x and
// y position); span_out gives one span per visible tile row (source offset,
// destination offset, width, last flag); cfg writes the six registers by
// index; the user must write them only while the block is idle, which the
// block itself does not enforce. All three channels use valid/ready, a
// transfer at a rising edge with both high.
// Sequence: a request is accepted only in idle. A clip check comes first,
// then the bit-serial divider that splits the tile index by the tileset
// column count, then the first and second multiply stages; the first span
// is then registered and further spans follow one per cycle while the
// receiver takes them. A rejected or fully clipped tile ends after the clip
// check and gives no span. The block takes one request at a time.
// Reset: rst_n clears the sequencer and the result valid and loads the
// register defaults. A stalled receiver holds the current span in the
// result register and freezes row stepping until it is taken.
module tile_blit_span_generator #(
    parameter int MAX_TILE_SIDE = tbs_pkg::DEF_MAX_TILE_SIDE,
    parameter int COORD_BITS    = tbs_pkg::DEF_COORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    tbs_cfg_if.sink     cfg,
    tbs_tile_if.sink    tile_in,
    tbs_span_if.source  span_out
);

    tbs_pkg::cfg_t       cfg_val;
    tbs_pkg::dp_cmd_t    cmd;
    tbs_pkg::dp_status_t status;
    logic                in_ready;

    // Registers are written only while idle by user rule, unchecked here, so always take the write
    assign cfg.ready     = 1'b1;
    assign tile_in.ready = in_ready;

    tbs_cfg_regs u_tbs_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    tbs_ctrl u_tbs_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tile_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tbs_dpath #(
        .MAX_TILE_SIDE (MAX_TILE_SIDE),
        .COORD_BITS    (COORD_BITS)
    ) u_tbs_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_val),
        .tile_index (tile_in.tile_index),
        .x_pos      (tile_in.x_pos),
        .y_pos      (tile_in.y_pos),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (span_out.ready),
        .out_valid  (span_out.valid),
        .src_addr   (span_out.src_addr),
        .dest_addr  (span_out.dest_addr),
        .span_width (span_out.span_width),
        .last_span  (span_out.last_span)
    );

endmodule

// ===== rtl/tbs_checker.sv =====
// Port-level checker of the span generator and its bind
`include "tile_blit_span_generator_defines.svh"

module tbs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [tbs_pkg::SRC_W-1:0]   src_addr,
    input logic [tbs_pkg::DST_W-1:0]   dest_addr,
    input logic [tbs_pkg::SIDE_W-1:0]  span_width,
    input logic                        last_span
);

    // A stalled span holds its contents
    `TBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(src_addr) && $stable(dest_addr) && $stable(span_width) && $stable(last_span), "span changed while stalled")

    // Spans are never empty and never wider than a tile can be
    `TBS_ASSERT(a_width_range, !out_valid || (span_width != '0 && span_width <= tbs_pkg::SPAN_CAP), "span width out of range")

    // One request at a time: no new request right after one is taken
    `TBS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request accepted while busy")

    // A taken span that is not the last one is followed at once by the next
    `TBS_ASSERT_NEXT(a_rows_back_to_back, out_valid && out_ready && !last_span, out_valid, "gap inside a tile's spans")

    // No new request while a tile still has rows to send
    `TBS_ASSERT(a_busy_while_rows, !(out_valid && !last_span) || !in_ready, "request taken in the middle of a tile")

endmodule

bind tile_blit_span_generator tbs_checker u_tbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (tile_in.valid),
    .in_ready   (tile_in.ready),
    .out_valid  (span_out.valid),
    .out_ready  (span_out.ready),
    .src_addr   (span_out.src_addr),
    .dest_addr  (span_out.dest_addr),
    .span_width (span_out.span_width),
    .last_span  (span_out.last_span)
);
